/* hw/rtl/rpp_pkg.sv */
// Shared constants for the range point projection pipeline.
// Fixed-point widths, the CORDIC arctangent table and the register and code names.
// No dependencies.
`default_nettype none
package rpp_pkg;

  localparam int unsigned LenW   = 19;  // lengths, box sizes, outputs
  localparam int unsigned PosW   = 20;  // start coordinates, offset vector
  localparam int unsigned AngW   = 16;  // input angles, 1/128 degree
  localparam int unsigned PrepW  = 18;  // angle after negate and wrap
  localparam int unsigned ZW     = 25;  // CORDIC angle accumulator, 1/65536 degree
  localparam int unsigned CW     = 20;  // CORDIC x and y, Q16
  localparam int unsigned RW     = 22;  // rotated coordinates
  localparam int unsigned PW     = 44;  // products
  localparam int unsigned SumW   = 23;  // coordinate plus start point
  localparam int unsigned Steps  = 16;
  localparam int unsigned StepsPerStage = 4;
  localparam int unsigned CfgIdxW = 3;

  localparam logic signed [PrepW-1:0] HalfTurn    = 18'sd23040;
  localparam logic signed [PrepW-1:0] FullTurn    = 18'sd46080;
  localparam logic signed [PrepW-1:0] QuarterTurn = 18'sd11520;
  localparam logic signed [CW-1:0]    CordicGain  = 20'sd39797;
  localparam logic signed [PW:0]      RoundBias   = 45'sd32768;

  localparam logic signed [ZW-1:0] Atan [Steps] = '{
    25'sd2949120, 25'sd1740967, 25'sd919879, 25'sd466945,
    25'sd234379,  25'sd117304,  25'sd58665,  25'sd29335,
    25'sd14668,   25'sd7334,    25'sd3667,   25'sd1833,
    25'sd917,     25'sd458,     25'sd229,    25'sd115
  };

  // Register indexes.
  localparam logic [CfgIdxW-1:0] RegMaxRange = 3'd0;
  localparam logic [CfgIdxW-1:0] RegMinRange = 3'd1;
  localparam logic [CfgIdxW-1:0] RegBoxX     = 3'd2;
  localparam logic [CfgIdxW-1:0] RegBoxY     = 3'd3;
  localparam logic [CfgIdxW-1:0] RegBoxZ     = 3'd4;

  // Opcodes and direction codes.
  localparam logic OpSensor = 1'b0;
  localparam logic [2:0] DirFront = 3'd0;
  localparam logic [2:0] DirBack  = 3'd1;
  localparam logic [2:0] DirLeft  = 3'd2;
  localparam logic [2:0] DirRight = 3'd3;
  localparam logic [2:0] DirUp    = 3'd4;
  localparam logic [2:0] DirDown  = 3'd5;

  // Angle slots in the CORDIC lanes.
  localparam int unsigned AxRoll  = 0;
  localparam int unsigned AxPitch = 1;
  localparam int unsigned AxYaw   = 2;

  typedef struct packed {
    logic                    pv;
    logic signed [PosW-1:0]  vx;
    logic signed [PosW-1:0]  vy;
    logic signed [PosW-1:0]  vz;
    logic signed [PosW-1:0]  sx;
    logic signed [PosW-1:0]  sy;
    logic signed [PosW-1:0]  sz;
    logic [2:0][CW-1:0]      cx;    // cosine lanes
    logic [2:0][CW-1:0]      cy;    // sine lanes
    logic [2:0][ZW-1:0]      cz;
    logic [2:0]              flip;
    logic signed [PW-1:0]    p0;
    logic signed [PW-1:0]    p1;
    logic signed [PW-1:0]    p2;
    logic signed [PW-1:0]    p3;
    logic signed [RW-1:0]    x1;
    logic signed [RW-1:0]    y1;
    logic signed [RW-1:0]    x2;
    logic signed [RW-1:0]    z2;
    logic signed [RW-1:0]    y3;
    logic signed [RW-1:0]    z3;
    logic [LenW-1:0]         ox;
    logic [LenW-1:0]         oy;
    logic [LenW-1:0]         oz;
  } pipe_t;

endpackage
`default_nettype wire

/* hw/rtl/range_point_projection.sv */
// Range point projection: twelve-stage pipeline, CORDIC sine/cosine and
// three rotations, each over a product and a round stage. Depends on rpp_pkg.
`default_nettype none
//
// Channel   Dir  Handshake                  Payload
// in        in   in_valid_i / in_ready_o    opcode, direction, range_len, angles, start
// out       out  out_valid_o / out_ready_i  point_valid, out_x, out_y, out_z
// cfg       in   cfg_we_i                   cfg_idx_i, cfg_wdata_i
//
// A result passes twelve register stages, the first loaded at the accepting edge; one
// word enters per cycle unless a stalled output has backed up to the first stage.
// The depth is set by the 16 CORDIC steps (four per stage, four stages)
// and by three rotations, each a product stage followed by a round stage.
// Reset clears the valid bits and loads the register defaults.
// Each stage holds only while it is full and the stage after it holds, so
// bubbles close up and a stalled output loses and repeats nothing.
module range_point_projection (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              cfg_we_i,
  input  wire [rpp_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  wire [rpp_pkg::LenW-1:0]          cfg_wdata_i,
  input  wire                              in_valid_i,
  output logic                             in_ready_o,
  input  wire                              opcode_i,
  input  wire [2:0]                        direction_i,
  input  wire [rpp_pkg::LenW-1:0]          range_len_i,
  input  wire signed [rpp_pkg::AngW-1:0]   roll_angle_i,
  input  wire signed [rpp_pkg::AngW-1:0]   pitch_angle_i,
  input  wire signed [rpp_pkg::AngW-1:0]   yaw_angle_i,
  input  wire signed [rpp_pkg::PosW-1:0]   start_x_i,
  input  wire signed [rpp_pkg::PosW-1:0]   start_y_i,
  input  wire signed [rpp_pkg::PosW-1:0]   start_z_i,
  output logic                             out_valid_o,
  input  wire                              out_ready_i,
  output logic                             point_valid_o,
  output logic [rpp_pkg::LenW-1:0]         out_x_o,
  output logic [rpp_pkg::LenW-1:0]         out_y_o,
  output logic [rpp_pkg::LenW-1:0]         out_z_o
);
  import rpp_pkg::*;

  localparam int unsigned NS = 12;
  localparam int unsigned CordicFirst = 1;
  localparam int unsigned CordicLast  = Steps / StepsPerStage;

  logic [LenW-1:0] max_range_q, min_range_q, box_x_q, box_y_q, box_z_q;
  pipe_t           pipe_q [NS];
  pipe_t           pipe_d [NS];
  logic [NS-1:0]   vld_q;
  logic [NS-1:0]   en;

  // Wrap into (-180, 180], then fold beyond +-90 toward zero.
  function automatic logic [ZW:0] prep_angle(input logic signed [PrepW-1:0] a);
    logic signed [PrepW-1:0] w;
    logic signed [PrepW-1:0] f;
    logic                    fl;
    logic signed [PrepW+8:0] zz;
    begin
      w = a;
      if (a > HalfTurn) begin
        w = a - FullTurn;
      end else if (a <= -HalfTurn) begin
        w = a + FullTurn;
      end
      f  = w;
      fl = 1'b0;
      if (w > QuarterTurn) begin
        f  = w - HalfTurn;
        fl = 1'b1;
      end else if (w < -QuarterTurn) begin
        f  = w + HalfTurn;
        fl = 1'b1;
      end
      zz = {f, 9'b0};
      return {fl, zz[ZW-1:0]};
    end
  endfunction

  function automatic logic signed [RW-1:0] round_q16(input logic signed [PW:0] s);
    logic signed [PW:0] t;
    begin
      t = (s + RoundBias) >>> 16;
      return t[RW-1:0];
    end
  endfunction

  function automatic logic [LenW-1:0] clamp_axis(input logic signed [RW-1:0] v,
                                                 input logic signed [PosW-1:0] s,
                                                 input logic [LenW-1:0] hi);
    logic signed [SumW-1:0] t;
    begin
      t = SumW'(v) + SumW'(s);
      if (t < 0) begin
        return '0;
      end else if (t > $signed({{(SumW-LenW){1'b0}}, hi})) begin
        return hi;
      end
      return t[LenW-1:0];
    end
  endfunction

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_range_q <= LenW'(48000);
      min_range_q <= LenW'(64);
      box_x_q     <= LenW'(16384);
      box_y_q     <= LenW'(16384);
      box_z_q     <= LenW'(16384);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegMaxRange: max_range_q <= cfg_wdata_i;
        RegMinRange: min_range_q <= cfg_wdata_i;
        RegBoxX:     box_x_q     <= cfg_wdata_i;
        RegBoxY:     box_y_q     <= cfg_wdata_i;
        RegBoxZ:     box_z_q     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // A stage advances when it is empty or the next one advances.
  always_comb begin
    en[NS-1] = !vld_q[NS-1] || out_ready_i;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  assign in_ready_o = en[0];

  // Stage 0: decode the offset, the range check and the CORDIC start angles.
  always_comb begin
    logic signed [PosW-1:0]  d;
    logic signed [PrepW-1:0] pa;
    logic [ZW:0]             pr, pp, py;
    pipe_d[0] = pipe_q[0];
    d  = $signed({1'b0, range_len_i});
    pa = PrepW'(pitch_angle_i);
    if (opcode_i == OpSensor) begin
      pa = -pa;
    end
    pipe_d[0].pv = (direction_i <= DirDown) &&
                   (opcode_i != OpSensor ||
                    (range_len_i < max_range_q && range_len_i > min_range_q));
    pipe_d[0].vx = '0;
    pipe_d[0].vy = '0;
    pipe_d[0].vz = '0;
    case (direction_i)
      DirFront: pipe_d[0].vx = d;
      DirBack:  pipe_d[0].vx = -d;
      DirLeft:  pipe_d[0].vy = d;
      DirRight: pipe_d[0].vy = -d;
      DirUp:    pipe_d[0].vz = d;
      DirDown:  pipe_d[0].vz = -d;
      default: ;
    endcase
    pipe_d[0].sx = start_x_i;
    pipe_d[0].sy = start_y_i;
    pipe_d[0].sz = start_z_i;
    pr = prep_angle(PrepW'(roll_angle_i));
    pp = prep_angle(pa);
    py = prep_angle(PrepW'(yaw_angle_i));
    pipe_d[0].cz[AxRoll]    = pr[ZW-1:0];
    pipe_d[0].cz[AxPitch]   = pp[ZW-1:0];
    pipe_d[0].cz[AxYaw]     = py[ZW-1:0];
    pipe_d[0].flip[AxRoll]  = pr[ZW];
    pipe_d[0].flip[AxPitch] = pp[ZW];
    pipe_d[0].flip[AxYaw]   = py[ZW];
    for (int a = 0; a < 3; a++) begin
      pipe_d[0].cx[a] = CordicGain;
      pipe_d[0].cy[a] = '0;
    end
  end

  // Stages 1 to 4: four CORDIC steps per stage on all three angles.
  for (genvar s = CordicFirst; s <= CordicLast; s++) begin : g_cordic
    always_comb begin
      logic signed [CW-1:0] x, y, xs, ys;
      logic signed [ZW-1:0] z;
      int unsigned          i;
      pipe_d[s] = pipe_q[s-1];
      for (int a = 0; a < 3; a++) begin
        x = $signed(pipe_q[s-1].cx[a]);
        y = $signed(pipe_q[s-1].cy[a]);
        z = $signed(pipe_q[s-1].cz[a]);
        for (int j = 0; j < StepsPerStage; j++) begin
          i  = (s - CordicFirst) * StepsPerStage + j;
          xs = x >>> i;
          ys = y >>> i;
          if (z >= 0) begin
            x = x - ys;
            y = y + xs;
            z = z - Atan[i];
          end else begin
            x = x + ys;
            y = y - xs;
            z = z + Atan[i];
          end
        end
        // Undo the fold toward zero after the last step.
        if (s == CordicLast && pipe_q[s-1].flip[a]) begin
          x = -x;
          y = -y;
        end
        pipe_d[s].cx[a] = x;
        pipe_d[s].cy[a] = y;
        pipe_d[s].cz[a] = z;
      end
    end
  end

  // Stages 5 to 11: yaw, pitch, roll rotations, then add the start and clamp.
  always_comb begin
    logic signed [CW-1:0] cyw, syw, cp, sp, cr, sr;
    cyw = $signed(pipe_q[4].cx[AxYaw]);
    syw = $signed(pipe_q[4].cy[AxYaw]);
    pipe_d[5]    = pipe_q[4];
    pipe_d[5].p0 = PW'(cyw) * PW'(pipe_q[4].vx);
    pipe_d[5].p1 = PW'(syw) * PW'(pipe_q[4].vy);
    pipe_d[5].p2 = PW'(syw) * PW'(pipe_q[4].vx);
    pipe_d[5].p3 = PW'(cyw) * PW'(pipe_q[4].vy);

    pipe_d[6]    = pipe_q[5];
    pipe_d[6].x1 = round_q16((PW+1)'(pipe_q[5].p0) - (PW+1)'(pipe_q[5].p1));
    pipe_d[6].y1 = round_q16((PW+1)'(pipe_q[5].p2) + (PW+1)'(pipe_q[5].p3));

    cp = $signed(pipe_q[6].cx[AxPitch]);
    sp = $signed(pipe_q[6].cy[AxPitch]);
    pipe_d[7]    = pipe_q[6];
    pipe_d[7].p0 = PW'(cp) * PW'(pipe_q[6].x1);
    pipe_d[7].p1 = PW'(sp) * PW'(pipe_q[6].vz);
    pipe_d[7].p2 = PW'(cp) * PW'(pipe_q[6].vz);
    pipe_d[7].p3 = PW'(sp) * PW'(pipe_q[6].x1);

    pipe_d[8]    = pipe_q[7];
    pipe_d[8].x2 = round_q16((PW+1)'(pipe_q[7].p0) + (PW+1)'(pipe_q[7].p1));
    pipe_d[8].z2 = round_q16((PW+1)'(pipe_q[7].p2) - (PW+1)'(pipe_q[7].p3));

    cr = $signed(pipe_q[8].cx[AxRoll]);
    sr = $signed(pipe_q[8].cy[AxRoll]);
    pipe_d[9]    = pipe_q[8];
    pipe_d[9].p0 = PW'(cr) * PW'(pipe_q[8].y1);
    pipe_d[9].p1 = PW'(sr) * PW'(pipe_q[8].z2);
    pipe_d[9].p2 = PW'(sr) * PW'(pipe_q[8].y1);
    pipe_d[9].p3 = PW'(cr) * PW'(pipe_q[8].z2);

    pipe_d[10]    = pipe_q[9];
    pipe_d[10].y3 = round_q16((PW+1)'(pipe_q[9].p0) - (PW+1)'(pipe_q[9].p1));
    pipe_d[10].z3 = round_q16((PW+1)'(pipe_q[9].p2) + (PW+1)'(pipe_q[9].p3));

    // Drop the point to zero when the word failed the direction or range check.
    pipe_d[11]    = pipe_q[10];
    pipe_d[11].ox = '0;
    pipe_d[11].oy = '0;
    pipe_d[11].oz = '0;
    if (pipe_q[10].pv) begin
      pipe_d[11].ox = clamp_axis(pipe_q[10].x2, pipe_q[10].sx, box_x_q);
      pipe_d[11].oy = clamp_axis(pipe_q[10].y3, pipe_q[10].sy, box_y_q);
      pipe_d[11].oz = clamp_axis(pipe_q[10].z3, pipe_q[10].sz, box_z_q);
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // Payload stages, no reset.
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NS; k++) begin
      if (en[k]) begin
        pipe_q[k] <= pipe_d[k];
      end
    end
  end

  assign out_valid_o   = vld_q[NS-1];
  assign point_valid_o = pipe_q[NS-1].pv;
  assign out_x_o       = pipe_q[NS-1].ox;
  assign out_y_o       = pipe_q[NS-1].oy;
  assign out_z_o       = pipe_q[NS-1].oz;

endmodule
`default_nettype wire

/* tb/sv/range_point_projection_tb.sv */
// Testbench for the range point projection pipeline: directed and random words,
// checked field by field against a behavioral projection with CORDIC sine/cosine.
// Depends on rpp_pkg and range_point_projection.
`timescale 1ns / 100ps

module range_point_projection_tb;
  import rpp_pkg::*;

  localparam int unsigned WatchdogLimit = 20000;

  typedef struct {
    logic            op;
    logic [2:0]      dir;
    logic [LenW-1:0] len;
    logic signed [AngW-1:0] roll, pitch, yaw;
    logic signed [PosW-1:0] sx, sy, sz;
  } sample_t;

  typedef struct {
    logic            pv;
    logic [LenW-1:0] x, y, z;
  } point_t;

  logic clk_i, rst_ni;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [LenW-1:0] cfg_wdata_i;
  logic in_valid_i, in_ready_o;
  logic opcode_i;
  logic [2:0] direction_i;
  logic [LenW-1:0] range_len_i;
  logic signed [AngW-1:0] roll_angle_i, pitch_angle_i, yaw_angle_i;
  logic signed [PosW-1:0] start_x_i, start_y_i, start_z_i;
  logic out_valid_o, out_ready_i, point_valid_o;
  logic [LenW-1:0] out_x_o, out_y_o, out_z_o;

  // Shadow copies of the registers, updated with every write.
  longint max_rng, min_rng, box_x, box_y, box_z;

  point_t pending_points[$];
  int errors;
  int idle_cycles;
  int send_idle_pct, stall_pct;
  bit timed_out;

  range_point_projection u_dut (.*);

  initial clk_i = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------
  function automatic longint fshift(longint v, int s);
    return v >>> s;   // arithmetic shift on a signed longint floors
  endfunction

  // CORDIC sine/cosine of an angle in 1/128 degree, Q16 results.
  function automatic void cordic_sincos(longint a, output longint s, output longint c);
    longint x, y, z, xs, ys;
    bit flip;
    x = CordicGain;
    y = 0;
    flip = 0;
    while (a > HalfTurn) a -= FullTurn;
    while (a <= -HalfTurn) a += FullTurn;
    if (a > QuarterTurn) begin
      a -= HalfTurn;
      flip = 1;
    end else if (a < -QuarterTurn) begin
      a += HalfTurn;
      flip = 1;
    end
    z = a * 512;
    for (int i = 0; i < Steps; i++) begin
      xs = fshift(x, i);
      ys = fshift(y, i);
      if (z >= 0) begin
        x = x - ys;
        y = y + xs;
        z -= longint'(Atan[i]);
      end else begin
        x = x + ys;
        y = y - xs;
        z += longint'(Atan[i]);
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    s = y;
    c = x;
  endfunction

  function automatic longint round_q16(longint v);
    return fshift(v + 32768, 16);
  endfunction

  function automatic logic [LenW-1:0] clamp_axis(longint v, longint hi);
    if (v < 0) return '0;
    if (v > hi) return hi[LenW-1:0];
    return v[LenW-1:0];
  endfunction

  function automatic point_t project_sample(sample_t s);
    point_t p;
    longint vx, vy, vz, d, pitch;
    longint sr, cr, sp, cp, syw, cyw, x1, y1, x2, z2, y3, z3;
    p = '{pv: 1'b0, x: '0, y: '0, z: '0};
    vx = 0; vy = 0; vz = 0;
    d = s.len;
    pitch = s.pitch;
    if (s.dir > DirDown) return p;
    if (s.op == OpSensor) begin
      if (!(d < max_rng && d > min_rng)) return p;
      pitch = -pitch;
    end
    case (s.dir)
      DirFront: vx = d;
      DirBack:  vx = -d;
      DirLeft:  vy = d;
      DirRight: vy = -d;
      DirUp:    vz = d;
      default:  vz = -d;
    endcase
    cordic_sincos(longint'(s.roll), sr, cr);
    cordic_sincos(pitch, sp, cp);
    cordic_sincos(longint'(s.yaw), syw, cyw);
    x1 = round_q16(cyw * vx - syw * vy);
    y1 = round_q16(syw * vx + cyw * vy);
    x2 = round_q16(cp * x1 + sp * vz);
    z2 = round_q16(cp * vz - sp * x1);
    y3 = round_q16(cr * y1 - sr * z2);
    z3 = round_q16(sr * y1 + cr * z2);
    p.pv = 1'b1;
    p.x = clamp_axis(x2 + s.sx, box_x);
    p.y = clamp_axis(y3 + s.sy, box_y);
    p.z = clamp_axis(z3 + s.sz, box_z);
    return p;
  endfunction

  // ---------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------
  // Write one register, then leave the port quiet.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [LenW-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      RegMaxRange: max_rng = val;
      RegMinRange: min_rng = val;
      RegBoxX:     box_x = val;
      RegBoxY:     box_y = val;
      RegBoxZ:     box_z = val;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // Send one word: idle at random first, then hold valid until accepted.
  // Valid stays high after the accepting edge; a drain, or the next send when it idles first, drops it.
  task automatic send_sample(sample_t s);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    opcode_i <= s.op;
    direction_i <= s.dir;
    range_len_i <= s.len;
    roll_angle_i <= s.roll;
    pitch_angle_i <= s.pitch;
    yaw_angle_i <= s.yaw;
    start_x_i <= s.sx;
    start_y_i <= s.sy;
    start_z_i <= s.sz;
    do @(posedge clk_i); while (!in_ready_o);
    // The word is taken at this edge; queue its expected point.
    pending_points.push_back(project_sample(s));
  endtask

  // Drop valid, then wait until every expected point is back.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_points.size() != 0 && !timed_out) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  function automatic logic signed [AngW-1:0] rand_angle();
    // Mostly the legal range, sometimes any 16-bit value to hit wrapping.
    if ($urandom_range(9) == 0) return AngW'($urandom);
    return AngW'($signed($urandom_range(46080)) - 23040);
  endfunction

  function automatic sample_t rand_sample();
    sample_t s;
    s.op = 1'($urandom);
    s.dir = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 6)) : 3'($urandom_range(5));
    case ($urandom_range(3))
      0: s.len = LenW'($urandom);
      1: s.len = LenW'($urandom_range(2000));
      default: s.len = LenW'($urandom_range(max_rng > 0 ? max_rng : 1));
    endcase
    s.roll = rand_angle();
    s.pitch = rand_angle();
    s.yaw = rand_angle();
    if ($urandom_range(3) == 0) begin
      s.sx = PosW'($urandom);
      s.sy = PosW'($urandom);
      s.sz = PosW'($urandom);
    end else begin
      s.sx = PosW'($urandom_range(box_x + 100));
      s.sy = PosW'($urandom_range(box_y + 100));
      s.sz = PosW'($urandom_range(box_z + 100));
    end
    return s;
  endfunction

  // ---------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------
  task automatic test_directed();
    sample_t s;
    // All eight direction codes, modes alternating, all tilted by pitch and yaw.
    for (int d = 0; d < 8; d++) begin
      s = '{op: d[0], dir: 3'(d), len: 19'd1000, roll: 16'sd0, pitch: 16'sd2000,
            yaw: 16'sd5760, sx: 20'sd8000, sy: 20'sd8000, sz: 20'sd8000};
      send_sample(s);
    end
    // Range edges in sensor mode: at min, just above, at max, just below.
    s = '{op: OpSensor, dir: DirFront, len: 19'(min_rng), roll: '0, pitch: '0, yaw: '0,
          sx: '0, sy: '0, sz: '0};
    send_sample(s);
    s.len = LenW'(min_rng + 1); send_sample(s);
    s.len = LenW'(max_rng);     send_sample(s);
    s.len = LenW'(max_rng - 1); send_sample(s);
    // Field extremes: angles at +-180 and beyond, start at both limits.
    s = '{op: 1'b1, dir: DirUp, len: '1, roll: 16'sd23040, pitch: -16'sd23040,
          yaw: 16'sh7fff, sx: 20'sh7ffff, sy: 20'sh80000, sz: 20'sh7ffff};
    send_sample(s);
    s = '{op: 1'b1, dir: DirDown, len: '1, roll: 16'sh8000, pitch: 16'sd11520,
          yaw: -16'sd11521, sx: 20'sh80000, sy: 20'sh7ffff, sz: 20'sh80000};
    send_sample(s);
    s = '{op: 1'b1, dir: DirBack, len: '0, roll: 16'sd11521, pitch: -16'sd11520,
          yaw: 16'sd23041, sx: 20'sd100, sy: 20'sd100, sz: 20'sd100};
    send_sample(s);
    s = '{op: OpSensor, dir: DirRight, len: 19'd30000, roll: -16'sd23039, pitch: 16'sd23039,
          yaw: 16'sh8000, sx: 20'sd16000, sy: 20'sd16000, sz: 20'sd16000};
    send_sample(s);
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) send_sample(rand_sample());
  endtask

  // Walk through idle mixes, including one with no idling at all.
  task automatic test_idle_phases(int per_phase);
    int send_mix[4] = '{0, 73, 0, 33};
    int stall_mix[4] = '{0, 0, 73, 33};
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = send_mix[ph];
      stall_pct = stall_mix[ph];
      test_random(per_phase);
    end
    send_idle_pct = 0;
    stall_pct = 0;
  endtask

  task automatic test_config_settings();
    // Extremes: zero window and zero box, then full-scale values.
    drain();
    write_reg(RegMaxRange, '0);
    write_reg(RegMinRange, '0);
    write_reg(RegBoxX, '0);
    write_reg(RegBoxY, '0);
    write_reg(RegBoxZ, '0);
    test_random(60);
    drain();
    write_reg(RegMaxRange, '1);
    write_reg(RegMinRange, '0);
    write_reg(RegBoxX, '1);
    write_reg(RegBoxY, '1);
    write_reg(RegBoxZ, '1);
    test_random(100);
    drain();
    // Inverted window: sensor mode can never pass.
    write_reg(RegMaxRange, 19'd100);
    write_reg(RegMinRange, '1);
    test_random(40);
    drain();
    write_reg(RegMaxRange, LenW'($urandom_range(60000, 20000)));
    write_reg(RegMinRange, LenW'($urandom_range(500)));
    write_reg(RegBoxX, LenW'($urandom_range(30000, 1000)));
    write_reg(RegBoxY, LenW'($urandom_range(30000, 1000)));
    write_reg(RegBoxZ, LenW'($urandom_range(30000, 1000)));
    test_idle_phases(60);
    drain();
  endtask

  // ---------------------------------------------------------------
  // Result checking and receiver stalls
  // ---------------------------------------------------------------
  always @(posedge clk_i) begin
    point_t exp_pt;
    if (rst_ni) begin
      out_ready_i <= ($urandom_range(99) >= stall_pct);
      if (out_valid_o && out_ready_i) begin
        if (pending_points.size() == 0) begin
          $display("%0t: unexpected point pv=%0b x=%0d y=%0d z=%0d", $time,
                   point_valid_o, out_x_o, out_y_o, out_z_o);
          errors++;
        end else begin
          exp_pt = pending_points.pop_front();
          if (point_valid_o !== exp_pt.pv || out_x_o !== exp_pt.x ||
              out_y_o !== exp_pt.y || out_z_o !== exp_pt.z) begin
            $display("%0t: expected pv=%0b x=%0d y=%0d z=%0d actual pv=%0b x=%0d y=%0d z=%0d",
                     $time, exp_pt.pv, exp_pt.x, exp_pt.y, exp_pt.z,
                     point_valid_o, out_x_o, out_y_o, out_z_o);
            errors++;
          end
        end
      end
    end
  end

  // Watchdog: count cycles with no word moving on either side.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == WatchdogLimit) begin
      timed_out = 1;
      $display("range_point_projection_tb: errors");
      $finish;
    end
  end

  initial begin
    errors = 0;
    idle_cycles = 0;
    timed_out = 0;
    send_idle_pct = 0;
    stall_pct = 0;
    max_rng = 48000; min_rng = 64;
    box_x = 16384; box_y = 16384; box_z = 16384;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0; cfg_idx_i = '0; cfg_wdata_i = '0;
    in_valid_i = 1'b0; out_ready_i = 1'b0;
    opcode_i = 1'b0; direction_i = '0; range_len_i = '0;
    roll_angle_i = '0; pitch_angle_i = '0; yaw_angle_i = '0;
    start_x_i = '0; start_y_i = '0; start_z_i = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_idle_phases(175);
    // Hold off the sender until the pipeline has emptied, then go on.
    drain();
    test_config_settings();
    drain();

    if (errors == 0) begin
      $display("range_point_projection_tb: clean");
    end else begin
      $display("range_point_projection_tb: errors");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/rpp_pkg.sv
hw/rtl/range_point_projection.sv
tb/sv/range_point_projection_tb.sv
